// File: sv/tcpi_pkg.sv
// Shared types and constants for the text chunk position index.
// Item structs, scan unit command/result structs and request codes.
// No dependencies; every other file imports this package.
package tcpi_pkg;

    localparam int POS_W   = 8;
    localparam int SLICE_W = 8;

    localparam logic [2:0] REQ_START        = 3'd0;
    localparam logic [2:0] REQ_APPEND       = 3'd1;
    localparam logic [2:0] REQ_TO_POINT     = 3'd2;
    localparam logic [2:0] REQ_FROM_POINT   = 3'd3;
    localparam logic [2:0] REQ_CHAR_TO_BYTE = 3'd4;
    localparam logic [2:0] REQ_BYTE_TO_CHAR = 3'd5;
    localparam logic [2:0] REQ_BYTE_TO_U16  = 3'd6;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] WIDE_LEAD    = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [7:0] position_a;
        logic [7:0] position_b;
    } tcpi_in_t;

    typedef struct packed {
        logic [8:0] answer_main;
        logic [7:0] answer_column;
        logic       was_clamped;
    } tcpi_out_t;

    typedef enum logic {
        SCAN_RANK,
        SCAN_SELECT
    } scan_op_t;

    typedef enum logic [1:0] {
        VEC_NEWLINE,
        VEC_BOUNDARY,
        VEC_WIDE
    } vec_sel_t;

    typedef struct packed {
        scan_op_t         op;
        vec_sel_t         vec;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] n;
    } scan_cmd_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
    } scan_res_t;

    typedef struct packed {
        logic [SLICE_W-1:0] newline;
        logic [SLICE_W-1:0] boundary;
        logic [SLICE_W-1:0] wide;
    } slice_bits_t;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic [7:0] byte_value;
    } load_t;

endpackage

// File: sv/tcpi_mark_store.sv
// Mark vectors and chunk length of the text chunk position index.
// Marks newline, character-boundary and wide-lead bytes as they are appended.
// Depends on tcpi_pkg.
module tcpi_mark_store #(
    parameter int CHUNK_BYTES = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcpi_pkg::load_t        load,
    input  logic [$clog2((CHUNK_BYTES + tcpi_pkg::SLICE_W - 1) / tcpi_pkg::SLICE_W)-1:0]
                                   slice_idx,
    output tcpi_pkg::slice_bits_t  slice_bits,
    output logic [tcpi_pkg::POS_W-1:0] chunk_len
);
    import tcpi_pkg::*;

    localparam int NSLICE = (CHUNK_BYTES + SLICE_W - 1) / SLICE_W;
    localparam int SIDX_W = $clog2(NSLICE);
    localparam int SBIT_W = $clog2(SLICE_W);
    localparam int MASK_W = NSLICE * SLICE_W;
    localparam int BIT_W  = $clog2(MASK_W);

    logic [MASK_W-1:0] newline_reg;
    logic [MASK_W-1:0] boundary_reg;
    logic [MASK_W-1:0] wide_reg;
    logic [POS_W-1:0]  len_reg;
    logic [BIT_W-1:0]  wr_bit;
    logic [SIDX_W+SBIT_W-1:0] rd_base;
    logic              has_room;

    assign wr_bit   = len_reg[BIT_W-1:0];
    assign has_room = len_reg < POS_W'(CHUNK_BYTES);
    assign rd_base  = {slice_idx, {SBIT_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newline_reg  <= '0;
            boundary_reg <= '0;
            wide_reg     <= '0;
            len_reg      <= '0;
        end else if (load.clear) begin
            newline_reg  <= '0;
            boundary_reg <= '0;
            wide_reg     <= '0;
            len_reg      <= '0;
        end else if (load.append && has_room) begin
            // Bytes 0xF0 and up are lead bytes, so a wide mark is also a boundary.
            if (load.byte_value == NEWLINE_BYTE) begin
                newline_reg[wr_bit] <= 1'b1;
            end
            if ((load.byte_value & CONT_MASK) != CONT_TAG) begin
                boundary_reg[wr_bit] <= 1'b1;
            end
            if (load.byte_value >= WIDE_LEAD) begin
                wide_reg[wr_bit] <= 1'b1;
            end
            len_reg <= len_reg + POS_W'(1);
        end
    end

    assign slice_bits.newline  = newline_reg[rd_base +: SLICE_W];
    assign slice_bits.boundary = boundary_reg[rd_base +: SLICE_W];
    assign slice_bits.wide     = wide_reg[rd_base +: SLICE_W];
    assign chunk_len           = len_reg;

endmodule

// File: sv/tcpi_scan_unit.sv
// Shared rank/select unit: walks one mark vector in 8-bit slices per cycle.
// Rank counts marks in [lo, hi); select finds the n-th mark there, else hi.
// Depends on tcpi_pkg.
module tcpi_scan_unit #(
    parameter int CHUNK_BYTES = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  scan_start,
    input  tcpi_pkg::scan_cmd_t   scan_cmd,
    input  tcpi_pkg::slice_bits_t slice_bits,
    output logic [$clog2((CHUNK_BYTES + tcpi_pkg::SLICE_W - 1) / tcpi_pkg::SLICE_W)-1:0]
                                  slice_idx,
    output tcpi_pkg::scan_res_t   scan_res
);
    import tcpi_pkg::*;

    localparam int NSLICE = (CHUNK_BYTES + SLICE_W - 1) / SLICE_W;
    localparam int SIDX_W = $clog2(NSLICE);
    localparam int SBIT_W = $clog2(SLICE_W);
    localparam int CNT_W  = $clog2(SLICE_W + 1);

    logic              busy_reg;
    scan_op_t          op_reg;
    vec_sel_t          vec_reg;
    logic [POS_W-1:0]  lo_reg;
    logic [POS_W-1:0]  hi_reg;
    logic [POS_W-1:0]  n_reg;
    logic [POS_W-1:0]  cnt_reg;
    logic [SIDX_W-1:0] slice_reg;
    scan_res_t         res_reg;

    logic [POS_W:0]       base;
    logic [POS_W:0]       bit_pos;
    logic [SLICE_W-1:0]   vec_bits;
    logic [SLICE_W-1:0]   win;
    logic [SLICE_W-1:0]   hits;
    logic [CNT_W-1:0]     hit_cnt;
    logic [CNT_W-1:0]     seen;
    logic                 sel_ok;
    logic [SBIT_W-1:0]    sel_idx;
    logic                 last;
    logic [POS_W-1:0]     cnt_sum;
    logic [POS_W-1:0]     sel_pos;

    always_comb begin
        base = (POS_W+1)'(slice_reg) << SBIT_W;
        case (vec_reg)
            VEC_NEWLINE:  vec_bits = slice_bits.newline;
            VEC_BOUNDARY: vec_bits = slice_bits.boundary;
            VEC_WIDE:     vec_bits = slice_bits.wide;
            default:      vec_bits = '0;
        endcase
        for (int j = 0; j < SLICE_W; j++) begin
            bit_pos = base + (POS_W+1)'(j);
            win[j]  = (bit_pos >= {1'b0, lo_reg}) && (bit_pos < {1'b0, hi_reg});
        end
        hits = vec_bits & win;

        hit_cnt = '0;
        seen    = '0;
        sel_ok  = 1'b0;
        sel_idx = '0;
        for (int j = 0; j < SLICE_W; j++) begin
            if (hits[j]) begin
                if (!sel_ok && POS_W'(seen) == n_reg) begin
                    sel_ok  = 1'b1;
                    sel_idx = SBIT_W'(j);
                end
                seen = seen + CNT_W'(1);
            end
        end
        hit_cnt = seen;

        last    = (base + (POS_W+1)'(SLICE_W) >= {1'b0, hi_reg}) ||
                  (slice_reg == SIDX_W'(NSLICE - 1));
        cnt_sum = cnt_reg + POS_W'(hit_cnt);
        sel_pos = base[POS_W-1:0] + POS_W'(sel_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            res_reg  <= '0;
        end else begin
            res_reg.done <= 1'b0;
            if (!busy_reg) begin
                if (scan_start) begin
                    op_reg  <= scan_cmd.op;
                    vec_reg <= scan_cmd.vec;
                    lo_reg  <= scan_cmd.lo;
                    hi_reg  <= scan_cmd.hi;
                    n_reg   <= scan_cmd.n;
                    cnt_reg <= '0;
                    // An empty range finishes at once; this also keeps the
                    // slice index inside the vector when lo sits at the end.
                    if (scan_cmd.lo >= scan_cmd.hi) begin
                        res_reg <= '{done: 1'b1, found: 1'b0, pos: scan_cmd.hi, count: '0};
                    end else begin
                        busy_reg  <= 1'b1;
                        slice_reg <= SIDX_W'(scan_cmd.lo >> SBIT_W);
                    end
                end
            end else if (op_reg == SCAN_SELECT && sel_ok) begin
                res_reg  <= '{done: 1'b1, found: 1'b1, pos: sel_pos, count: cnt_sum};
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_sum;
                n_reg   <= n_reg - POS_W'(hit_cnt);
                if (last) begin
                    res_reg  <= '{done: 1'b1, found: 1'b0, pos: hi_reg, count: cnt_sum};
                    busy_reg <= 1'b0;
                end else begin
                    slice_reg <= slice_reg + SIDX_W'(1);
                end
            end
        end
    end

    assign slice_idx = slice_reg;
    assign scan_res  = res_reg;

endmodule

// File: sv/text_chunk_position_index_core.sv
// Text chunk position index: holds one chunk of text and answers position queries.
// s_ channel takes request items (start chunk, append byte, or one of five queries);
// m_ channel returns one result item for each query and none for load items.
// A load item is taken on acceptance and the next item can follow directly. A query is
// split into up to four passes of the shared rank/select scan unit, which reads
// one 8-bit slice of a mark vector per cycle. After the last pass the answer waits in
// ST_DONE until the output register is free and then loads it. A query that needs no
// pass goes straight to ST_DONE; the longest, a point-to-offset over a full 128-byte
// chunk, takes four passes.
// While a query runs, s_ready is low. A finished result sits in the output
// register until m_ready takes it; the next item is accepted meanwhile, and a
// following query holds its answer until the output register is free.
// Reset (aresetn low, synchronous) empties the chunk, clears all marks and drops
// any pending result. Bytes past CHUNK_BYTES are dropped; offsets past the
// chunk length clamp to the length. Request code 7 is ignored.
// Depends on tcpi_pkg, tcpi_mark_store and tcpi_scan_unit.
module text_chunk_position_index_core #(
    parameter int CHUNK_BYTES = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcpi_pkg::tcpi_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcpi_pkg::tcpi_out_t m_data
);
    import tcpi_pkg::*;

    localparam int NSLICE = (CHUNK_BYTES + SLICE_W - 1) / SLICE_W;
    localparam int SIDX_W = $clog2(NSLICE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_ROW_START,
        ST_COLUMN,
        ST_LINE,
        ST_LINE_END,
        ST_LINE_TOTAL,
        ST_LINE_COL,
        ST_CHAR,
        ST_RANK,
        ST_U16_BASE,
        ST_U16_WIDE,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic             scan_start_reg;
    scan_cmd_t        scan_cmd_reg;
    logic [POS_W-1:0] off_reg;
    logic [POS_W-1:0] pb_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] rs_reg;
    logic [POS_W-1:0] re_reg;
    tcpi_out_t        ans_reg;
    logic             m_valid_reg;
    tcpi_out_t        m_data_reg;

    load_t             load;
    slice_bits_t       slice_bits;
    logic [SIDX_W-1:0] slice_idx;
    logic [POS_W-1:0]  chunk_len;
    scan_res_t         scan_res;
    logic              accept;
    logic [POS_W-1:0]  off_in;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign off_in   = (s_data.position_a > chunk_len) ? chunk_len : s_data.position_a;
    assign out_free = !m_valid_reg || m_ready;

    assign load.clear      = accept && (s_data.req_type == REQ_START);
    assign load.append     = accept && (s_data.req_type == REQ_APPEND);
    assign load.byte_value = s_data.byte_value;

    tcpi_mark_store #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .slice_idx (slice_idx),
        .slice_bits(slice_bits),
        .chunk_len (chunk_len)
    );

    tcpi_scan_unit #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_start(scan_start_reg),
        .scan_cmd  (scan_cmd_reg),
        .slice_bits(slice_bits),
        .slice_idx (slice_idx),
        .scan_res  (scan_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            scan_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        off_reg <= off_in;
                        pb_reg  <= s_data.position_b;
                        ans_reg <= '0;
                        case (s_data.req_type)
                            REQ_TO_POINT: begin
                                scan_start_reg <= 1'b1;
                                scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_NEWLINE,
                                                    lo: '0, hi: off_in, n: '0};
                                state_reg      <= ST_ROW;
                            end
                            REQ_FROM_POINT: begin
                                rs_reg <= '0;
                                if (s_data.position_a != '0) begin
                                    scan_start_reg <= 1'b1;
                                    scan_cmd_reg   <= '{op: SCAN_SELECT, vec: VEC_NEWLINE,
                                                        lo: '0, hi: chunk_len,
                                                        n: s_data.position_a - POS_W'(1)};
                                    state_reg      <= ST_LINE;
                                end else if (s_data.position_b == '0) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    scan_start_reg <= 1'b1;
                                    scan_cmd_reg   <= '{op: SCAN_SELECT, vec: VEC_NEWLINE,
                                                        lo: '0, hi: chunk_len, n: '0};
                                    state_reg      <= ST_LINE_END;
                                end
                            end
                            REQ_CHAR_TO_BYTE: begin
                                if (s_data.position_a == '0) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    scan_start_reg <= 1'b1;
                                    scan_cmd_reg   <= '{op: SCAN_SELECT, vec: VEC_BOUNDARY,
                                                        lo: '0, hi: chunk_len,
                                                        n: s_data.position_a};
                                    state_reg      <= ST_CHAR;
                                end
                            end
                            REQ_BYTE_TO_CHAR: begin
                                scan_start_reg <= 1'b1;
                                scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_BOUNDARY,
                                                    lo: '0, hi: off_in, n: '0};
                                state_reg      <= ST_RANK;
                            end
                            REQ_BYTE_TO_U16: begin
                                scan_start_reg <= 1'b1;
                                scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_BOUNDARY,
                                                    lo: '0, hi: off_in, n: '0};
                                state_reg      <= ST_U16_BASE;
                            end
                            default: begin
                                // Load items are handled by the mark store.
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_ROW: begin
                    if (scan_res.done) begin
                        row_reg        <= scan_res.count;
                        scan_start_reg <= 1'b1;
                        if (scan_res.count == '0) begin
                            scan_cmd_reg <= '{op: SCAN_RANK, vec: VEC_BOUNDARY,
                                              lo: '0, hi: off_reg, n: '0};
                            state_reg    <= ST_COLUMN;
                        end else begin
                            // Find the last newline below the offset.
                            scan_cmd_reg <= '{op: SCAN_SELECT, vec: VEC_NEWLINE,
                                              lo: '0, hi: off_reg,
                                              n: scan_res.count - POS_W'(1)};
                            state_reg    <= ST_ROW_START;
                        end
                    end
                end
                ST_ROW_START: begin
                    if (scan_res.done) begin
                        scan_start_reg <= 1'b1;
                        scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_BOUNDARY,
                                            lo: scan_res.pos + POS_W'(1), hi: off_reg,
                                            n: '0};
                        state_reg      <= ST_COLUMN;
                    end
                end
                ST_COLUMN: begin
                    if (scan_res.done) begin
                        ans_reg.answer_main   <= {1'b0, row_reg};
                        ans_reg.answer_column <= scan_res.count;
                        state_reg             <= ST_DONE;
                    end
                end
                ST_LINE: begin
                    if (scan_res.done) begin
                        if (!scan_res.found) begin
                            // The row lies past the last line.
                            ans_reg.answer_main <= {1'b0, chunk_len};
                            ans_reg.was_clamped <= 1'b1;
                            state_reg           <= ST_DONE;
                        end else if (pb_reg == '0) begin
                            ans_reg.answer_main <= {1'b0, scan_res.pos + POS_W'(1)};
                            state_reg           <= ST_DONE;
                        end else begin
                            rs_reg         <= scan_res.pos + POS_W'(1);
                            scan_start_reg <= 1'b1;
                            scan_cmd_reg   <= '{op: SCAN_SELECT, vec: VEC_NEWLINE,
                                                lo: scan_res.pos + POS_W'(1),
                                                hi: chunk_len, n: '0};
                            state_reg      <= ST_LINE_END;
                        end
                    end
                end
                ST_LINE_END: begin
                    if (scan_res.done) begin
                        re_reg         <= scan_res.pos;
                        scan_start_reg <= 1'b1;
                        scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_BOUNDARY,
                                            lo: rs_reg, hi: scan_res.pos, n: '0};
                        state_reg      <= ST_LINE_TOTAL;
                    end
                end
                ST_LINE_TOTAL: begin
                    if (scan_res.done) begin
                        if (pb_reg >= scan_res.count) begin
                            ans_reg.answer_main <= {1'b0, re_reg};
                            ans_reg.was_clamped <= (pb_reg > scan_res.count);
                            state_reg           <= ST_DONE;
                        end else begin
                            scan_start_reg <= 1'b1;
                            scan_cmd_reg   <= '{op: SCAN_SELECT, vec: VEC_BOUNDARY,
                                                lo: rs_reg, hi: re_reg, n: pb_reg};
                            state_reg      <= ST_LINE_COL;
                        end
                    end
                end
                ST_LINE_COL, ST_CHAR: begin
                    if (scan_res.done) begin
                        ans_reg.answer_main <= {1'b0, scan_res.pos};
                        state_reg           <= ST_DONE;
                    end
                end
                ST_RANK: begin
                    if (scan_res.done) begin
                        ans_reg.answer_main <= {1'b0, scan_res.count};
                        state_reg           <= ST_DONE;
                    end
                end
                ST_U16_BASE: begin
                    if (scan_res.done) begin
                        row_reg        <= scan_res.count;
                        scan_start_reg <= 1'b1;
                        scan_cmd_reg   <= '{op: SCAN_RANK, vec: VEC_WIDE,
                                            lo: '0, hi: off_reg, n: '0};
                        state_reg      <= ST_U16_WIDE;
                    end
                end
                ST_U16_WIDE: begin
                    if (scan_res.done) begin
                        // Wide lead bytes add a second UTF-16 unit each.
                        ans_reg.answer_main <= {1'b0, row_reg} + {1'b0, scan_res.count};
                        state_reg           <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= ans_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A scan pass only finishes while the sequencer is waiting on one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_res.done |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("scan result arrived with no pass outstanding");

    // A mark that a select finds always lies inside the stored text.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_res.done && scan_res.found) |-> (scan_res.pos < chunk_len))
        else $error("select returned a position past the chunk length");

    // A finished answer moves to the output register once that register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished answer was not presented");

    // No new pass is started while the chunk length exceeds its capacity or while s_ready is high.
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start_reg |-> (chunk_len <= POS_W'(CHUNK_BYTES) && !s_ready))
        else $error("scan started with inconsistent chunk state");

endmodule

// File: dv/text_chunk_position_index_core_tb.sv
// Self-checking testbench for text_chunk_position_index_core.
// Loads text chunks byte by byte, queries positions and compares each result against
// a scoreboard with its own rank/select predictor. Depends on tcpi_pkg and the core.
`timescale 1ns / 1ps

module text_chunk_position_index_core_tb;

    import tcpi_pkg::*;

    localparam int         CHUNK_BYTES = 128;
    localparam int         IDX_W       = $clog2(CHUNK_BYTES);
    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int         STALL_CYCLES = 400;

    class chunk_index_scoreboard;
        logic [7:0]   text_mem [CHUNK_BYTES];
        logic [127:0] newline_mask;
        logic [127:0] boundary_mask;
        int unsigned  fill;
        tcpi_out_t    pending_answers[$];
        int unsigned  errors;

        function new();
            newline_mask  = '0;
            boundary_mask = '0;
            fill          = 0;
            errors        = 0;
        endfunction

        // Number of marks in [lo, hi).
        function int unsigned count_marks(logic [127:0] mask, int unsigned lo, int unsigned hi);
            int unsigned n;
            n = 0;
            for (int unsigned i = lo; i < hi && i < CHUNK_BYTES; i++)
                if (mask[IDX_W'(i)]) n++;
            return n;
        endfunction

        // Position of the n-th mark (from zero) in [lo, hi), or hi when there is none.
        function int unsigned find_mark(logic [127:0] mask, int unsigned n, int unsigned lo,
                                        int unsigned hi, output bit found);
            int unsigned left;
            left  = n;
            found = 1'b0;
            for (int unsigned i = lo; i < hi && i < CHUNK_BYTES; i++) begin
                if (mask[IDX_W'(i)]) begin
                    if (left == 0) begin
                        found = 1'b1;
                        return i;
                    end
                    left--;
                end
            end
            return hi;
        endfunction

        function int unsigned clamp_offset(int unsigned off);
            return (off > fill) ? fill : off;
        endfunction

        // Updates the chunk state and returns 1 when the item produces a result.
        function bit compute_answer(tcpi_in_t req, output tcpi_out_t ans);
            int unsigned off, line_start, row_base, row_end, total, nl, main_v, col_v;
            int unsigned pa, pb;
            bit          clamp_v, found;
            main_v  = 0;
            col_v   = 0;
            clamp_v = 1'b0;
            pa      = 32'(req.position_a);
            pb      = 32'(req.position_b);
            ans     = '0;
            case (req.req_type)
                REQ_START: begin
                    newline_mask  = '0;
                    boundary_mask = '0;
                    fill          = 0;
                    return 1'b0;
                end
                REQ_APPEND: begin
                    if (fill < CHUNK_BYTES) begin
                        text_mem[IDX_W'(fill)] = req.byte_value;
                        if (req.byte_value == NEWLINE_BYTE)
                            newline_mask[IDX_W'(fill)] = 1'b1;
                        if ((req.byte_value & CONT_MASK) != CONT_TAG)
                            boundary_mask[IDX_W'(fill)] = 1'b1;
                        fill++;
                    end
                    return 1'b0;
                end
                REQ_TO_POINT: begin
                    off        = clamp_offset(pa);
                    line_start = 0;
                    main_v     = count_marks(newline_mask, 0, off);
                    for (int unsigned i = 0; i < off; i++)
                        if (newline_mask[IDX_W'(i)]) line_start = i + 1;
                    col_v = count_marks(boundary_mask, line_start, off);
                end
                REQ_FROM_POINT: begin
                    row_base = 0;
                    if (pa > 0) begin
                        nl = find_mark(newline_mask, pa - 1, 0, fill, found);
                        if (!found) begin
                            // Row lies past the last line of the chunk.
                            main_v  = fill;
                            clamp_v = 1'b1;
                        end else begin
                            row_base = nl + 1;
                        end
                    end
                    if (!clamp_v) begin
                        if (pb == 0) begin
                            main_v = row_base;
                        end else begin
                            row_end = find_mark(newline_mask, 0, row_base, fill, found);
                            total   = count_marks(boundary_mask, row_base, row_end);
                            if (pb >= total) begin
                                main_v  = row_end;
                                clamp_v = (pb > total);
                            end else begin
                                main_v = find_mark(boundary_mask, pb, row_base, row_end, found);
                            end
                        end
                    end
                end
                REQ_CHAR_TO_BYTE: begin
                    if (pa == 0) main_v = 0;
                    else main_v = find_mark(boundary_mask, pa, 0, fill, found);
                end
                REQ_BYTE_TO_CHAR: begin
                    main_v = count_marks(boundary_mask, 0, clamp_offset(pa));
                end
                REQ_BYTE_TO_U16: begin
                    off = clamp_offset(pa);
                    for (int unsigned i = 0; i < off && i < CHUNK_BYTES; i++) begin
                        if (boundary_mask[IDX_W'(i)]) begin
                            main_v++;
                            // Four-byte lead bytes stand for a surrogate pair.
                            if (text_mem[IDX_W'(i)] >= WIDE_LEAD) main_v++;
                        end
                    end
                end
                default: return 1'b0;
            endcase
            ans.answer_main   = main_v[8:0];
            ans.answer_column = col_v[7:0];
            ans.was_clamped   = clamp_v;
            return 1'b1;
        endfunction

        function void note_request(tcpi_in_t req);
            tcpi_out_t ans;
            if (compute_answer(req, ans)) pending_answers.push_back(ans);
        endfunction

        function void check_answer(tcpi_out_t actual);
            tcpi_out_t expected;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b",
                         $time, actual.answer_main, actual.answer_column, actual.was_clamped);
                errors++;
                return;
            end
            expected = pending_answers.pop_front();
            if (actual !== expected) begin
                $display("%0t: mismatch, expected main/col/clamp %0d/%0d/%0b, actual %0d/%0d/%0b",
                         $time, expected.answer_main, expected.answer_column,
                         expected.was_clamped, actual.answer_main, actual.answer_column,
                         actual.was_clamped);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tcpi_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tcpi_out_t m_data;

    chunk_index_scoreboard sb = new();

    int unsigned sent_items    = 0;
    bit          quiet_run     = 1'b0;
    bit          stall_request = 1'b0;
    bit          pressure_done = 1'b0;
    int unsigned stall_left    = 0;

    text_chunk_position_index_core #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic tcpi_in_t make_req(logic [2:0] req, logic [7:0] b, logic [7:0] pa,
                                          logic [7:0] pb);
        tcpi_in_t item;
        item.req_type   = req;
        item.byte_value = b;
        item.position_a = pa;
        item.position_b = pb;
        return item;
    endfunction

    task automatic send_item(input tcpi_in_t item);
        while (!quiet_run && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(item);
        if (item.req_type != REQ_UNUSED) sent_items++;
    endtask

    task automatic send_append(input logic [7:0] b);
        send_item(make_req(REQ_APPEND, b, 8'($urandom), 8'($urandom)));
    endtask

    // Appends a mix of ASCII, newlines and UTF-8 sequences, now and then malformed.
    task automatic append_text(input int unsigned count);
        int unsigned done_bytes, pick, seq_len;
        logic [7:0]  lead;
        done_bytes = 0;
        while (done_bytes < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_append(NEWLINE_BYTE);
                done_bytes++;
            end else if (pick < 60) begin
                send_append(8'($urandom_range(8'h20, 8'h7E)));
                done_bytes++;
            end else if (pick < 88) begin
                seq_len = $urandom_range(2, 4);
                case (seq_len)
                    2: lead = 8'($urandom_range(8'hC2, 8'hDF));
                    3: lead = 8'($urandom_range(8'hE0, 8'hEF));
                    default: lead = 8'($urandom_range(8'hF0, 8'hFF));
                endcase
                send_append(lead);
                done_bytes++;
                for (int unsigned k = 1; k < seq_len && done_bytes < count; k++) begin
                    send_append({2'b10, 6'($urandom)});
                    done_bytes++;
                end
            end else begin
                send_append(8'($urandom));
                done_bytes++;
            end
        end
    endtask

    function automatic logic [7:0] pick_position(int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 8'hFF;
        if (pick < 20) return 8'($urandom);
        return 8'($urandom_range(0, span + 2));
    endfunction

    task automatic send_queries(input int unsigned count);
        int unsigned rows, chars;
        logic [7:0]  pb;
        for (int unsigned k = 0; k < count; k++) begin
            rows  = sb.count_marks(sb.newline_mask, 0, sb.fill);
            chars = sb.count_marks(sb.boundary_mask, 0, sb.fill);
            case ($urandom_range(0, 4))
                0: send_item(make_req(REQ_TO_POINT, 8'($urandom), pick_position(sb.fill),
                                      8'($urandom)));
                1: begin
                    pb = ($urandom_range(0, 4) == 0) ? 8'd0 : pick_position(chars);
                    send_item(make_req(REQ_FROM_POINT, 8'($urandom), pick_position(rows), pb));
                end
                2: send_item(make_req(REQ_CHAR_TO_BYTE, 8'($urandom), pick_position(chars),
                                      8'($urandom)));
                3: send_item(make_req(REQ_BYTE_TO_CHAR, 8'($urandom), pick_position(sb.fill),
                                      8'($urandom)));
                default: send_item(make_req(REQ_BYTE_TO_U16, 8'($urandom),
                                            pick_position(sb.fill), 8'($urandom)));
            endcase
        end
    endtask

    // Result side: random back-pressure, a quiet stretch and one long hold-off.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = STALL_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_run || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_answer(m_data);
    end

    initial begin
        int unsigned chunk_no, pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queries on the empty chunk straight out of reset.
        send_item(make_req(REQ_TO_POINT, 8'h00, 8'h00, 8'h00));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'h00, 8'h00));
        send_item(make_req(REQ_BYTE_TO_U16, 8'hFF, 8'hFF, 8'hFF));
        // Three lines: "a", a two-byte and a four-byte character, then "b".
        send_item(make_req(REQ_START, 8'hFF, 8'hFF, 8'hFF));
        send_append(8'h61);
        send_append(NEWLINE_BYTE);
        send_append(8'hC3);
        send_append(8'hA9);
        send_append(8'hF0);
        send_append(8'h9F);
        send_append(8'h98);
        send_append(8'h80);
        send_append(NEWLINE_BYTE);
        send_append(8'h62);
        send_item(make_req(REQ_TO_POINT, 8'h00, 8'hFF, 8'h00));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'd9, 8'd0));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'd1, 8'd0));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'd1, 8'd2));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'd1, 8'd200));
        send_item(make_req(REQ_FROM_POINT, 8'h00, 8'd1, 8'd1));
        send_item(make_req(REQ_CHAR_TO_BYTE, 8'h00, 8'd0, 8'h00));
        send_item(make_req(REQ_CHAR_TO_BYTE, 8'h00, 8'hFF, 8'h00));
        send_item(make_req(REQ_BYTE_TO_CHAR, 8'h00, 8'd4, 8'h00));
        send_item(make_req(REQ_BYTE_TO_U16, 8'h00, 8'hFF, 8'h00));
        send_item(make_req(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF));

        chunk_no = 0;
        while (sent_items < 1140) begin
            quiet_run = (sent_items >= 550 && sent_items < 700);
            if (!pressure_done && sent_items >= 300) begin
                stall_request = 1'b1;
                pressure_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (chunk_no == 0 || pick < 5) begin
                // A chunk that fills to capacity or runs past it, so tail bytes may get dropped.
                send_item(make_req(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom)));
                append_text($urandom_range(CHUNK_BYTES, CHUNK_BYTES + 8));
                send_queries($urandom_range(4, 10));
            end else if (pick < 80) begin
                // Most chunks are short; some extend the current chunk instead.
                if (pick >= 15)
                    send_item(make_req(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom)));
                append_text($urandom_range(0, 40));
                send_queries($urandom_range(2, 8));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(make_req(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                                       8'($urandom)));
            end
            chunk_no++;
        end
        quiet_run = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
